// ----- sv/ncps_pkg.sv -----
// Shared types and constants for the nearest-camera pixel selector.
// Depends on nothing; used by nearest_camera_pixel_select.
`default_nettype none

package ncps_pkg;

   // Four camera views: front, back, left, right.
   localparam int NUM_CAMS = 4;
   localparam int PIX_W    = 24;
   localparam int CAM_W    = 2;
   localparam int CSR_IDX_W = 3;

   typedef logic [PIX_W-1:0]     pixel_type;
   typedef logic [CAM_W-1:0]     cam_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // Camera codes, also the order of precedence on equal distance.
   localparam cam_type CAM_FRONT = 2'd0;
   localparam cam_type CAM_BACK  = 2'd1;
   localparam cam_type CAM_LEFT  = 2'd2;
   localparam cam_type CAM_RIGHT = 2'd3;

   // Configuration register indexes.
   localparam csr_idx_type REG_FRONT_X = 3'd0;
   localparam csr_idx_type REG_FRONT_Y = 3'd1;
   localparam csr_idx_type REG_BACK_X  = 3'd2;
   localparam csr_idx_type REG_BACK_Y  = 3'd3;
   localparam csr_idx_type REG_LEFT_X  = 3'd4;
   localparam csr_idx_type REG_LEFT_Y  = 3'd5;
   localparam csr_idx_type REG_RIGHT_X = 3'd6;
   localparam csr_idx_type REG_RIGHT_Y = 3'd7;

   // Camera positions after reset.
   localparam int RST_FRONT_X = 625;
   localparam int RST_FRONT_Y = 500;
   localparam int RST_BACK_X  = 625;
   localparam int RST_BACK_Y  = 1300;
   localparam int RST_LEFT_X  = 500;
   localparam int RST_LEFT_Y  = 800;
   localparam int RST_RIGHT_X = 750;
   localparam int RST_RIGHT_Y = 800;

endpackage

`default_nettype wire

// ----- sv/nearest_camera_pixel_select.sv -----
// Nearest-camera pixel selector: top level and whole datapath.
// Depends on ncps_pkg for camera codes, register indexes and pixel types.
`default_nettype none

// One beat is accepted on every clock at which start is high; busy is always low, so
// the block takes one pixel position per clock with no gaps. Each beat comes out
// on rsp_strobe in the order it went in. The pipeline depth is set by the integer
// square root, which retires one root bit per pipeline stage for each of the four
// cameras, plus one stage for the differences, one for the squares, one for
// the pairwise compare and one for the output register. The receiver cannot stall
// the block; results must be taken as they come. Camera positions are written
// through the csr_ port and should change only while no beat is in flight.
module nearest_camera_pixel_select #(
   parameter int COORD_BITS = 11
) (
   input  wire                          clock,
   input  wire                          reset,
   // Configuration writes.
   input  wire                          csr_we,
   input  wire ncps_pkg::csr_idx_type   csr_index,
   input  wire [COORD_BITS-1:0]         csr_wdata,
   // Request beat.
   input  wire                          start,
   output logic                         busy,
   input  wire [COORD_BITS-1:0]         req_col,
   input  wire [COORD_BITS-1:0]         req_row,
   input  wire ncps_pkg::pixel_type     req_pix_front,
   input  wire ncps_pkg::pixel_type     req_pix_back,
   input  wire ncps_pkg::pixel_type     req_pix_left,
   input  wire ncps_pkg::pixel_type     req_pix_right,
   // Response beat.
   output logic                         rsp_strobe,
   output ncps_pkg::pixel_type          rsp_out_pixel,
   output ncps_pkg::cam_type            rsp_source_camera
);

   localparam int NC    = ncps_pkg::NUM_CAMS;
   localparam int R_W   = COORD_BITS + 1;   // root width
   localparam int V_W   = 2 * R_W;          // radicand width, padded to whole digits
   localparam int REM_W = R_W + 2;          // remainder width
   localparam int P_END = R_W + 1;          // last square-root stage
   localparam int LAT   = R_W + 4;          // registers from accept to response

   // Configuration registers.
   logic [COORD_BITS-1:0] cam_x_ff [NC];
   logic [COORD_BITS-1:0] cam_y_ff [NC];

   // Stage 0: absolute differences; stage 1: squared distance.
   logic [COORD_BITS-1:0] dx_in [NC];
   logic [COORD_BITS-1:0] dy_in [NC];
   logic [COORD_BITS-1:0] dx_ff [NC];
   logic [COORD_BITS-1:0] dy_ff [NC];
   logic [V_W-1:0]        sum_in [NC];

   // Square-root pipeline, stages 1 to P_END.
   logic                  vld_ff  [0:P_END];
   ncps_pkg::pixel_type   pix_ff  [0:P_END][NC];
   logic [V_W-1:0]        val_ff  [1:P_END][NC];
   logic [REM_W-1:0]      rem_ff  [1:P_END][NC];
   logic [R_W-1:0]        root_ff [1:P_END][NC];
   logic [REM_W-1:0]      rem_in  [2:P_END][NC];
   logic [R_W-1:0]        root_in [2:P_END][NC];

   // Pairwise compare stage.
   logic                  c1_vld_ff;
   logic [R_W-1:0]        c1_dist_a_ff;
   logic [R_W-1:0]        c1_dist_b_ff;
   ncps_pkg::cam_type     c1_cam_a_ff;
   ncps_pkg::cam_type     c1_cam_b_ff;
   ncps_pkg::pixel_type   c1_pix_a_ff;
   ncps_pkg::pixel_type   c1_pix_b_ff;
   logic                  b_wins_a_in;
   logic                  b_wins_b_in;

   // Output registers.
   logic                  rsp_strobe_ff;
   ncps_pkg::pixel_type   rsp_pixel_ff;
   ncps_pkg::cam_type     rsp_cam_ff;

   // The pipeline never stalls.
   assign busy = 1'b0;

   // Configuration writes; index bit 0 picks y over x, the upper bits the camera.
   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff[0] <= COORD_BITS'(ncps_pkg::RST_FRONT_X);
         cam_y_ff[0] <= COORD_BITS'(ncps_pkg::RST_FRONT_Y);
         cam_x_ff[1] <= COORD_BITS'(ncps_pkg::RST_BACK_X);
         cam_y_ff[1] <= COORD_BITS'(ncps_pkg::RST_BACK_Y);
         cam_x_ff[2] <= COORD_BITS'(ncps_pkg::RST_LEFT_X);
         cam_y_ff[2] <= COORD_BITS'(ncps_pkg::RST_LEFT_Y);
         cam_x_ff[3] <= COORD_BITS'(ncps_pkg::RST_RIGHT_X);
         cam_y_ff[3] <= COORD_BITS'(ncps_pkg::RST_RIGHT_Y);
      end else if (csr_we) begin
         unique case (csr_index)
            ncps_pkg::REG_FRONT_X: cam_x_ff[0] <= csr_wdata;
            ncps_pkg::REG_FRONT_Y: cam_y_ff[0] <= csr_wdata;
            ncps_pkg::REG_BACK_X:  cam_x_ff[1] <= csr_wdata;
            ncps_pkg::REG_BACK_Y:  cam_y_ff[1] <= csr_wdata;
            ncps_pkg::REG_LEFT_X:  cam_x_ff[2] <= csr_wdata;
            ncps_pkg::REG_LEFT_Y:  cam_y_ff[2] <= csr_wdata;
            ncps_pkg::REG_RIGHT_X: cam_x_ff[3] <= csr_wdata;
            ncps_pkg::REG_RIGHT_Y: cam_y_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Absolute coordinate differences against each camera.
   always_comb begin
      for (int c = 0; c < NC; c++) begin
         dx_in[c] = (req_col >= cam_x_ff[c]) ? req_col - cam_x_ff[c] : cam_x_ff[c] - req_col;
         dy_in[c] = (req_row >= cam_y_ff[c]) ? req_row - cam_y_ff[c] : cam_y_ff[c] - req_row;
      end
   end

   // Squared Euclidean distance, one multiplier pair per camera.
   always_comb begin
      for (int c = 0; c < NC; c++) begin
         sum_in[c] = V_W'(dx_ff[c] * dx_ff[c]) + V_W'(dy_ff[c] * dy_ff[c]);
      end
   end

   // One root digit per stage: bring down two radicand bits, try q*4+1.
   always_comb begin
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      for (int p = 2; p <= P_END; p++) begin
         for (int c = 0; c < NC; c++) begin
            rem_sh = {rem_ff[p-1][c][REM_W-3:0], val_ff[p-1][c][2*(P_END-p)+1 -: 2]};
            trial  = {root_ff[p-1][c], 2'b01};
            if (rem_sh >= trial) begin
               rem_in[p][c]  = rem_sh - trial;
               root_in[p][c] = {root_ff[p-1][c][R_W-2:0], 1'b1};
            end else begin
               rem_in[p][c]  = rem_sh;
               root_in[p][c] = {root_ff[p-1][c][R_W-2:0], 1'b0};
            end
         end
      end
   end

   // Valid bits through the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p <= P_END; p++) begin
            vld_ff[p] <= 1'b0;
         end
         c1_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         vld_ff[0] <= start;
         for (int p = 1; p <= P_END; p++) begin
            vld_ff[p] <= vld_ff[p-1];
         end
         c1_vld_ff     <= vld_ff[P_END];
         rsp_strobe_ff <= c1_vld_ff;
      end
   end

   // Datapath registers: differences, squares, root digits and pixels.
   always_ff @(posedge clock) begin
      pix_ff[0][0] <= req_pix_front;
      pix_ff[0][1] <= req_pix_back;
      pix_ff[0][2] <= req_pix_left;
      pix_ff[0][3] <= req_pix_right;
      for (int c = 0; c < NC; c++) begin
         dx_ff[c]      <= dx_in[c];
         dy_ff[c]      <= dy_in[c];
         val_ff[1][c]  <= sum_in[c];
         rem_ff[1][c]  <= '0;
         root_ff[1][c] <= '0;
         for (int p = 1; p <= P_END; p++) begin
            pix_ff[p][c] <= pix_ff[p-1][c];
         end
         for (int p = 2; p <= P_END; p++) begin
            val_ff[p][c]  <= val_ff[p-1][c];
            rem_ff[p][c]  <= rem_in[p][c];
            root_ff[p][c] <= root_in[p][c];
         end
      end
   end

   // Pairwise compare; the earlier camera keeps the pair on equal distance.
   assign b_wins_a_in = root_ff[P_END][1] < root_ff[P_END][0];
   assign b_wins_b_in = root_ff[P_END][3] < root_ff[P_END][2];

   always_ff @(posedge clock) begin
      c1_dist_a_ff <= b_wins_a_in ? root_ff[P_END][1] : root_ff[P_END][0];
      c1_cam_a_ff  <= b_wins_a_in ? ncps_pkg::CAM_BACK : ncps_pkg::CAM_FRONT;
      c1_pix_a_ff  <= b_wins_a_in ? pix_ff[P_END][1] : pix_ff[P_END][0];
      c1_dist_b_ff <= b_wins_b_in ? root_ff[P_END][3] : root_ff[P_END][2];
      c1_cam_b_ff  <= b_wins_b_in ? ncps_pkg::CAM_RIGHT : ncps_pkg::CAM_LEFT;
      c1_pix_b_ff  <= b_wins_b_in ? pix_ff[P_END][3] : pix_ff[P_END][2];
   end

   // Final pick between the front/back and left/right winners.
   always_ff @(posedge clock) begin
      if (c1_dist_b_ff < c1_dist_a_ff) begin
         rsp_pixel_ff <= c1_pix_b_ff;
         rsp_cam_ff   <= c1_cam_b_ff;
      end else begin
         rsp_pixel_ff <= c1_pix_a_ff;
         rsp_cam_ff   <= c1_cam_a_ff;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_out_pixel     = rsp_pixel_ff;
   assign rsp_source_camera = rsp_cam_ff;

`ifndef SYNTHESIS
   // A response beat always traces back to an earlier request beat.
   a_strobe_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LAT))
      else $error("response beat without a matching request beat");

   // Each finished root is the floor square root of its radicand.
   for (genvar gc = 0; gc < NC; gc++) begin : g_root_chk
      a_root_exact: assert property (@(posedge clock) disable iff (reset)
         vld_ff[P_END] |->
            ((V_W+2)'(root_ff[P_END][gc]) * (V_W+2)'(root_ff[P_END][gc])
               <= (V_W+2)'(val_ff[P_END][gc])) &&
            (((V_W+2)'(root_ff[P_END][gc]) + 1'b1) * ((V_W+2)'(root_ff[P_END][gc]) + 1'b1)
               > (V_W+2)'(val_ff[P_END][gc])))
         else $error("square root stage gave a wrong root");
   end

   // Each pair winner holds the smaller distance of its pair.
   a_pair_min: assert property (@(posedge clock) disable iff (reset)
      c1_vld_ff |->
         c1_dist_a_ff <= $past(root_ff[P_END][0]) && c1_dist_a_ff <= $past(root_ff[P_END][1]) &&
         c1_dist_b_ff <= $past(root_ff[P_END][2]) && c1_dist_b_ff <= $past(root_ff[P_END][3]))
      else $error("pairwise compare kept the larger distance");
`endif

endmodule

`default_nettype wire
